>>> rtl/core/hrzd_pkg.sv
// Shared types and constants of the Huffman zero-run decoder.
package hrzd_pkg;

   // Result word field widths.
   localparam int VALUE_W  = 8;
   localparam int RUN_W    = 15;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 24;

   // Decoder phases.
   localparam logic [2:0] PH_FLAG  = 3'd0;
   localparam logic [2:0] PH_SYM   = 3'd1;
   localparam logic [2:0] PH_WALK  = 3'd2;
   localparam logic [2:0] PH_EXTRA = 3'd3;
   localparam logic [2:0] PH_PAD   = 3'd4;
   localparam logic [2:0] PH_DONE  = 3'd5;

   // Completion status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_TREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_END  = 2'd3;

   // Symbol boundaries.
   localparam int SYM_LAST_BYTE = 255;
   localparam int SYM_RUN2      = 256;
   localparam int SYM_RUN_FIRST = 257;
   localparam int SYM_RUN_LAST  = 260;

   // One result word as produced by the decode core.
   typedef struct packed {
      logic                valid;
      logic [VALUE_W-1:0]  value;
      logic [RUN_W-1:0]    run;
      logic                done;
      logic [STATUS_W-1:0] status;
   } result_type;

   // Number of extra bits for each long zero-run class.
   function automatic logic [3:0] run_width(input logic [1:0] kind);
      logic [3:0] w;
      case (kind)
         2'd0:    w = 4'd2;
         2'd1:    w = 4'd4;
         2'd2:    w = 4'd8;
         default: w = 4'd14;
      endcase
      return w;
   endfunction

   // Shortest run of each long zero-run class.
   function automatic logic [RUN_W-1:0] run_base(input logic [1:0] kind);
      logic [RUN_W-1:0] b;
      case (kind)
         2'd0:    b = 15'd3;
         2'd1:    b = 15'd7;
         2'd2:    b = 15'd23;
         default: b = 15'd279;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/huffman_rle_zero_decoder_unit.sv
// Top level of the Huffman decoder with zero run-length tokens.
//
// Unless rsp stalls, req takes one compressed word per cycle: one bit of the
// stream, least significant bit of each byte first, with tlast on the final
// bit. The first bits describe the code tree in preorder; the rest are code
// words. The rsp channel gives at most one word per input word: a byte or a
// zero run (value, run_length) and, on the last word, tlast with a status in
// tuser. The csr channel writes output_length, the expected decoded byte count;
// the user must write it only while the decoder is idle, which the block does
// not enforce. The result of each input word appears on rsp in the cycle after
// acceptance. The tree walk reads both children of the current node from the
// node table ahead of time, so one word per cycle is sustained unless rsp stalls.
// Reset clears the control state and output_length; the node table needs no
// clearing. While rsp stalls with a word held, req takes a word only in a
// cycle where the held word leaves. After the final word, further input is
// accepted and dropped until reset.
module huffman_rle_zero_decoder_unit #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int SYMBOL_BITS  = 9,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] stream_bit, zero fill above
   input  logic        req_tlast,   // stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] value, [22:8] run_length, zero fill
   output logic        rsp_tlast,   // done_res
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data     // output_length
);

   logic [hrzd_pkg::LEN_W-1:0] length_ff;
   logic                       step;
   hrzd_pkg::result_type       res;
   logic                       rsp_valid_ff, rsp_valid_in;
   hrzd_pkg::result_type       rsp_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   // Expected output length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_valid) begin
         length_ff <= csr_data;
      end
   end

   hrzd_core #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SYMBOL_BITS (SYMBOL_BITS),
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (step),
      .stream_bit   (req_tdata[0]),
      .stream_end   (req_tlast),
      .output_length(length_ff),
      .res          (res)
   );

   // Output register.
   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || (step && res.valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.run, rsp_ff.value};
   assign rsp_tlast  = rsp_ff.done;
   assign rsp_tuser  = rsp_ff.status;

endmodule

>>> rtl/core/hrzd_node_mem.sv
// Node table memory with one write port and two registered read ports.
module hrzd_node_mem #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr0,
   input  logic [AW-1:0]    rd_addr1,
   output logic [WIDTH-1:0] rd_data0,
   output logic [WIDTH-1:0] rd_data1
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports; a read of the entry being written returns the new data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= (wr_en && wr_addr == rd_addr0) ? wr_data : mem[rd_addr0];
         rd_data1_ff <= (wr_en && wr_addr == rd_addr1) ? wr_data : mem[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

>>> rtl/core/hrzd_core.sv
// Tree build and tree walk sequencer of the Huffman zero-run decoder.
module hrzd_core #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int SYMBOL_BITS  = 9,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_valid,
   input  logic                      stream_bit,
   input  logic                      stream_end,
   input  logic [hrzd_pkg::LEN_W-1:0] output_length,
   output hrzd_pkg::result_type      res
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int SW    = $clog2(MAX_CODE_LEN);
   localparam int ACC_W = (SYMBOL_BITS > 14) ? SYMBOL_BITS : 14;
   localparam int AE_W  = SYMBOL_BITS + 1;

   // Registers.
   logic [2:0]                  phase_ff, phase_in;
   logic [AW:0]                 nodes_used_ff, nodes_used_in;
   logic [SW:0]                 stack_level_ff, stack_level_in;
   logic [AW-1:0]               stack_ff [MAX_CODE_LEN];
   logic [AW-1:0]               cur_node_ff, cur_node_in;
   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic [3:0]                  cnt_ff, cnt_in;
   logic [hrzd_pkg::LEN_W-1:0]  bytes_out_ff, bytes_out_in;
   logic [2:0]                  pad_ff, pad_in;
   logic [1:0]                  kind_ff, kind_in;
   logic [AW-1:0]               child0_ff, child0_in;
   logic [AW-1:0]               child1_ff, child1_in;
   logic [AW-1:0]               root_second_ff, root_second_in;

   // Memory ports.
   logic            a_we, b_we, rd_en;
   logic [AW-1:0]   a_waddr, b_waddr;
   logic [AE_W-1:0] a_wdata, a_rd0, a_rd1;
   logic [AW-1:0]   b_wdata, b_rd0, b_rd1;
   logic            stack_we;

   // Decision flags.
   logic                           do_fail, do_emit, do_conclude, chk_end;
   logic [hrzd_pkg::STATUS_W-1:0]  fail_code;
   logic [hrzd_pkg::VALUE_W-1:0]   ev;
   logic [hrzd_pkg::RUN_W-1:0]     er;
   logic [hrzd_pkg::LEN_W:0]       sum;
   logic                           conc;

   // Walk signals.
   logic                   c_leaf;
   logic [SYMBOL_BITS-1:0] c_sym;
   logic [AW-1:0]          c_idx, c_second, pop_idx;
   logic [SYMBOL_BITS-1:0] sym_off;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
      return (i == AW'(TABLE_DEPTH - 1)) ? '0 : i + AW'(1);
   endfunction

   // Leaf flag and symbol of each node.
   hrzd_node_mem #(.WIDTH(AE_W), .DEPTH(TABLE_DEPTH), .AW(AW)) u_leaf_mem (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_en   (rd_en),
      .rd_addr0(child0_in),
      .rd_addr1(child1_in),
      .rd_data0(a_rd0),
      .rd_data1(a_rd1)
   );

   // Second-child index of each internal node.
   hrzd_node_mem #(.WIDTH(AW), .DEPTH(TABLE_DEPTH), .AW(AW)) u_second_mem (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_en   (rd_en),
      .rd_addr0(child0_in),
      .rd_addr1(child1_in),
      .rd_data0(b_rd0),
      .rd_data1(b_rd1)
   );

   // The prefetched entries of both children of the current node.
   assign c_idx    = stream_bit ? child1_ff : child0_ff;
   assign c_leaf   = stream_bit ? a_rd1[SYMBOL_BITS] : a_rd0[SYMBOL_BITS];
   assign c_sym    = stream_bit ? a_rd1[SYMBOL_BITS-1:0] : a_rd0[SYMBOL_BITS-1:0];
   assign c_second = stream_bit ? b_rd1 : b_rd0;
   assign pop_idx  = stack_ff[SW'(stack_level_ff - (SW+1)'(1))];
   assign sym_off  = c_sym - SYMBOL_BITS'(hrzd_pkg::SYM_RUN_FIRST);

   // Next-state and result logic for one accepted bit.
   always_comb begin
      phase_in       = phase_ff;
      nodes_used_in  = nodes_used_ff;
      stack_level_in = stack_level_ff;
      cur_node_in    = cur_node_ff;
      acc_in         = acc_ff | (ACC_W'(stream_bit) << cnt_ff);
      cnt_in         = cnt_ff + 4'd1;
      bytes_out_in   = bytes_out_ff;
      pad_in         = pad_ff + 3'd1;
      kind_in        = kind_ff;
      child0_in      = child0_ff;
      child1_in      = child1_ff;
      root_second_in = root_second_ff;
      a_we = 1'b0; a_waddr = cur_node_ff; a_wdata = '0;
      b_we = 1'b0; b_waddr = pop_idx;     b_wdata = nodes_used_ff[AW-1:0];
      rd_en = 1'b0; stack_we = 1'b0;
      do_fail = 1'b0; fail_code = hrzd_pkg::ST_OK;
      do_emit = 1'b0; do_conclude = 1'b0; chk_end = 1'b0;
      ev = '0; er = '0; sum = '0; conc = 1'b0;
      res = '0;

      if (step_valid) begin
         unique case (phase_ff)
            hrzd_pkg::PH_FLAG: begin
               nodes_used_in = nodes_used_ff + (AW+1)'(1);
               if (nodes_used_ff >= (AW+1)'(TABLE_DEPTH - 1)) begin
                  do_fail = 1'b1; fail_code = hrzd_pkg::ST_BAD_TREE;
               end else if (stream_bit) begin
                  if (nodes_used_ff == '0) begin
                     do_fail = 1'b1; fail_code = hrzd_pkg::ST_BAD_TREE;
                  end else begin
                     cur_node_in = nodes_used_ff[AW-1:0];
                     acc_in = '0; cnt_in = '0;
                     phase_in = hrzd_pkg::PH_SYM;
                     chk_end = 1'b1;
                  end
               end else if (stack_level_ff >= (SW+1)'(MAX_CODE_LEN)) begin
                  do_fail = 1'b1; fail_code = hrzd_pkg::ST_BAD_TREE;
               end else begin
                  a_we = 1'b1; a_waddr = nodes_used_ff[AW-1:0]; a_wdata = '0;
                  stack_we = 1'b1;
                  stack_level_in = stack_level_ff + (SW+1)'(1);
                  chk_end = 1'b1;
               end
            end
            hrzd_pkg::PH_SYM: begin
               if (cnt_in < 4'(SYMBOL_BITS)) begin
                  chk_end = 1'b1;
               end else begin
                  a_we = 1'b1;
                  a_wdata = {1'b1, acc_in[SYMBOL_BITS-1:0]};
                  if (stack_level_ff == '0) begin
                     phase_in = hrzd_pkg::PH_WALK;
                     child0_in = AW'(1); child1_in = root_second_ff; rd_en = 1'b1;
                     if (output_length == '0) do_conclude = 1'b1;
                     else chk_end = 1'b1;
                  end else begin
                     stack_level_in = stack_level_ff - (SW+1)'(1);
                     b_we = 1'b1;
                     if (pop_idx == '0) root_second_in = nodes_used_ff[AW-1:0];
                     phase_in = hrzd_pkg::PH_FLAG;
                     chk_end = 1'b1;
                  end
               end
            end
            hrzd_pkg::PH_WALK: begin
               if (!c_leaf) begin
                  child0_in = next_idx(c_idx); child1_in = c_second; rd_en = 1'b1;
                  chk_end = 1'b1;
               end else if (c_sym <= SYMBOL_BITS'(hrzd_pkg::SYM_RUN2)) begin
                  child0_in = AW'(1); child1_in = root_second_ff; rd_en = 1'b1;
                  do_emit = 1'b1;
                  if (c_sym == SYMBOL_BITS'(hrzd_pkg::SYM_RUN2)) begin
                     er = hrzd_pkg::RUN_W'(2);
                  end else begin
                     ev = c_sym[hrzd_pkg::VALUE_W-1:0]; er = hrzd_pkg::RUN_W'(1);
                  end
               end else if (c_sym <= SYMBOL_BITS'(hrzd_pkg::SYM_RUN_LAST)) begin
                  kind_in = sym_off[1:0];
                  acc_in = '0; cnt_in = '0;
                  phase_in = hrzd_pkg::PH_EXTRA;
                  chk_end = 1'b1;
               end else begin
                  do_fail = 1'b1; fail_code = hrzd_pkg::ST_BAD_TREE;
               end
            end
            hrzd_pkg::PH_EXTRA: begin
               if (cnt_in < hrzd_pkg::run_width(kind_ff)) begin
                  chk_end = 1'b1;
               end else begin
                  phase_in = hrzd_pkg::PH_WALK;
                  child0_in = AW'(1); child1_in = root_second_ff; rd_en = 1'b1;
                  do_emit = 1'b1;
                  er = hrzd_pkg::RUN_W'(acc_in) + hrzd_pkg::run_base(kind_ff);
               end
            end
            hrzd_pkg::PH_PAD: begin
               do_conclude = 1'b1;
            end
            default: begin
               phase_in = hrzd_pkg::PH_DONE;
               pad_in = pad_ff;
            end
         endcase

         // Byte counting and the end-of-output check.
         if (do_emit) begin
            sum = {1'b0, bytes_out_ff} + (hrzd_pkg::LEN_W+1)'(er);
            if (sum > {1'b0, output_length}) begin
               do_fail = 1'b1; fail_code = hrzd_pkg::ST_OVERFLOW;
            end else begin
               bytes_out_in = sum[hrzd_pkg::LEN_W-1:0];
               if (sum[hrzd_pkg::LEN_W-1:0] >= output_length) begin
                  conc = 1'b1;
               end else begin
                  res.valid = 1'b1; res.value = ev; res.run = er;
                  if (stream_end) begin
                     phase_in = hrzd_pkg::PH_DONE;
                     res.done = 1'b1; res.status = hrzd_pkg::ST_BAD_END;
                  end
               end
            end
         end
         if (do_conclude) conc = 1'b1;

         // Failure, the padding rule once every byte is out, and an early stream end.
         if (do_fail) begin
            phase_in = hrzd_pkg::PH_DONE;
            res = '0;
            res.valid = 1'b1; res.done = 1'b1; res.status = fail_code;
         end else if (conc) begin
            if (pad_in == '0 || stream_end) begin
               phase_in = hrzd_pkg::PH_DONE;
               res.valid = 1'b1; res.value = ev; res.run = er; res.done = 1'b1;
               res.status = (pad_in == '0 && stream_end) ? hrzd_pkg::ST_OK
                                                        : hrzd_pkg::ST_BAD_END;
            end else begin
               phase_in = hrzd_pkg::PH_PAD;
               if (er != '0) begin
                  res.valid = 1'b1; res.value = ev; res.run = er;
               end
            end
         end else if (chk_end && stream_end) begin
            phase_in = hrzd_pkg::PH_DONE;
            res.valid = 1'b1; res.done = 1'b1; res.status = hrzd_pkg::ST_BAD_END;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= hrzd_pkg::PH_FLAG;
         nodes_used_ff  <= '0;
         stack_level_ff <= '0;
         acc_ff         <= '0;
         cnt_ff         <= '0;
         bytes_out_ff   <= '0;
         pad_ff         <= '0;
         kind_ff        <= '0;
         root_second_ff <= '0;
      end else if (step_valid) begin
         phase_ff       <= phase_in;
         nodes_used_ff  <= nodes_used_in;
         stack_level_ff <= stack_level_in;
         acc_ff         <= acc_in;
         cnt_ff         <= cnt_in;
         bytes_out_ff   <= bytes_out_in;
         pad_ff         <= pad_in;
         kind_ff        <= kind_in;
         root_second_ff <= root_second_in;
      end
   end

   // Node pointers and the branch stack.
   always_ff @(posedge clock) begin
      if (step_valid) begin
         cur_node_ff <= cur_node_in;
         child0_ff   <= child0_in;
         child1_ff   <= child1_in;
      end
      if (step_valid && stack_we) begin
         stack_ff[stack_level_ff[SW-1:0]] <= nodes_used_ff[AW-1:0];
      end
   end

   // The branch stack never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      stack_level_ff <= (SW+1)'(MAX_CODE_LEN))
      else $error("branch stack overrun");

   // Once decoding has ended it stays ended.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == hrzd_pkg::PH_DONE |=> phase_ff == hrzd_pkg::PH_DONE)
      else $error("decoder left the done phase");

   // A result only comes from an accepted bit.
   assert property (@(posedge clock) disable iff (reset)
      res.valid |-> step_valid)
      else $error("result without an accepted bit");

   // A final result moves the decoder to the done phase.
   assert property (@(posedge clock) disable iff (reset)
      res.valid && res.done |=> phase_ff == hrzd_pkg::PH_DONE)
      else $error("final result without ending");

   // The tree walk only runs on a complete tree.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hrzd_pkg::PH_WALK || phase_ff == hrzd_pkg::PH_EXTRA)
         |-> stack_level_ff == '0)
      else $error("walking an incomplete tree");

endmodule
